// File: rtl/jsu_pkg.sv
package jsu_pkg;

  localparam int unsigned NBUF = 6;
  localparam int unsigned CW   = 3;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [15:0] CP_REPL     = 16'hFFFD;
  localparam logic [15:0] CP_HIGH_LO  = 16'hD800;
  localparam logic [15:0] CP_HIGH_HI  = 16'hDBFF;
  localparam logic [15:0] CP_LOW_LO   = 16'hDC00;
  localparam logic [15:0] CP_LOW_HI   = 16'hDFFF;

  // utf-8 of the replacement character, first byte lowest
  localparam logic [2:0][7:0] REPL_UTF8 = {8'hBD, 8'hBF, 8'hEF};

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } enc_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] esc_char(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6E:   r = 8'h0A;
      8'h74:   r = 8'h09;
      8'h72:   r = 8'h0D;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic enc_t utf8_enc(input logic [15:0] cp);
    enc_t e;
    e.b = '0;
    if (cp < 16'h0080) begin
      e.b[0] = cp[7:0];
      e.n    = 2'd1;
    end else if (cp < 16'h0800) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.n    = 2'd2;
    end else begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.n    = 2'd3;
    end
    return e;
  endfunction

endpackage

// File: rtl/json_string_unescape_utf8.sv
// an accepted input item is registered in the input stage; its results are then loaded into
// the result shift buffer. throughput: one input item per cycle while m_tready is high and
// each item yields at most one result; more results stall input (the byte shift buffer)
// items with no result (escape prefixes, hex digits) pass without using the output
// reset: synchronous; clears decoder mode, hex state, pending surrogate and both stages
module json_string_unescape_utf8 (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // in_byte
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,   // out_byte
  output logic                    m_tlast,
  output logic                    m_tuser    // string_end
);
  import jsu_pkg::*;

  logic             in_valid;
  logic [7:0]       in_byte;

  logic [1:0]       mode, mode_next;
  logic [11:0]      hex_accum, hex_accum_next;
  logic [1:0]       hex_count, hex_count_next;
  logic             hex_bad, hex_bad_next;
  logic             high_pending, high_pending_next;

  logic [NBUF-1:0][7:0] obuf;
  logic [CW-1:0]        rem;
  logic                 oend;

  logic [NBUF-1:0][7:0] nb;
  logic [CW-1:0]        ncnt;
  logic                 nend;
  logic                 flush;
  enc_t                 main_enc;
  logic [15:0]          cp;
  logic [3:0]           dig;
  logic                 bad;
  logic                 cp_low, cp_high;
  logic                 advance, load, take;

  always_comb begin
    dig     = hex_val(in_byte);
    cp      = {hex_accum, dig};
    bad     = hex_bad | ~is_hex(in_byte);
    cp_low  = (cp >= CP_LOW_LO) && (cp <= CP_LOW_HI);
    cp_high = (cp >= CP_HIGH_LO) && (cp <= CP_HIGH_HI);

    mode_next         = mode;
    hex_accum_next    = hex_accum;
    hex_count_next    = hex_count;
    hex_bad_next      = hex_bad;
    high_pending_next = high_pending;
    flush             = 1'b0;
    nend              = 1'b0;
    main_enc          = '0;

    case (mode)
      MODE_HEX: begin
        if (hex_count != 2'd3) begin
          hex_accum_next = cp[11:0];
          hex_count_next = hex_count + 2'd1;
          hex_bad_next   = bad;
        end else begin
          mode_next         = MODE_TEXT;
          hex_accum_next    = '0;
          hex_count_next    = '0;
          hex_bad_next      = 1'b0;
          flush             = high_pending;
          high_pending_next = 1'b0;
          if (!(high_pending && !bad && cp_low)) begin
            if (bad || cp_low) begin
              main_enc = utf8_enc(CP_REPL);
            end else if (cp_high) begin
              high_pending_next = 1'b1;
            end else begin
              main_enc = utf8_enc(cp);
            end
          end
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_U) begin
          mode_next      = MODE_HEX;
          hex_accum_next = '0;
          hex_count_next = '0;
          hex_bad_next   = 1'b0;
        end else begin
          mode_next         = MODE_TEXT;
          flush             = high_pending;
          high_pending_next = 1'b0;
          main_enc.b[0]     = esc_char(in_byte);
          main_enc.n        = 2'd1;
        end
      end
      default: begin
        if (in_byte == CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          flush             = high_pending;
          high_pending_next = 1'b0;
          main_enc.n        = 2'd1;
          if (in_byte == CH_QUOTE) begin
            nend           = 1'b1;
            mode_next      = MODE_TEXT;
            hex_accum_next = '0;
            hex_count_next = '0;
            hex_bad_next   = 1'b0;
          end else begin
            main_enc.b[0] = in_byte;
          end
        end
      end
    endcase

    if (flush) begin
      nb   = {main_enc.b, REPL_UTF8};
      ncnt = CW'(3) + CW'(main_enc.n);
    end else begin
      nb   = {24'h000000, main_enc.b};
      ncnt = CW'(main_enc.n);
    end
  end

  assign take     = m_tvalid && m_tready;
  assign advance  = in_valid &&
                    ((ncnt == '0) || (rem == '0) || ((rem == CW'(1)) && m_tready));
  assign load     = advance && (ncnt != '0);
  assign s_tready = !in_valid || advance;

  assign m_tvalid = (rem != '0);
  assign m_tdata  = obuf[0];
  assign m_tlast  = (rem == CW'(1));
  assign m_tuser  = oend && (rem == CW'(1));

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_TEXT;
      hex_accum    <= '0;
      hex_count    <= '0;
      hex_bad      <= 1'b0;
      high_pending <= 1'b0;
    end else if (advance) begin
      mode         <= mode_next;
      hex_accum    <= hex_accum_next;
      hex_count    <= hex_count_next;
      hex_bad      <= hex_bad_next;
      high_pending <= high_pending_next;
    end
  end

  // result shift buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      oend <= 1'b0;
    end else if (load) begin
      rem  <= ncnt;
      oend <= nend;
    end else if (take) begin
      rem  <= rem - CW'(1);
    end
    if (load) begin
      obuf <= nb;
    end else if (take) begin
      obuf <= {8'h00, obuf[NBUF-1:1]};
    end
  end

endmodule

// File: rtl/jsu_checker.sv
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // string end terminator is always the single last byte of its run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("string end not on last byte");

  a_end_nul: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == 8'h00))
    else $error("string end byte not zero");

  // a run of result bytes is delivered without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a result run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output item changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

// File: tb/sv/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam logic [7:0] ESC_N      = "n";
  localparam logic [7:0] ESC_T      = "t";
  localparam logic [7:0] ESC_R      = "r";
  localparam logic [7:0] ESC_B      = "b";
  localparam logic [7:0] ESC_F      = "f";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_F = "f";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_F = "F";
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       str_end;
  } utf8_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  // decoder state as predicted
  logic [1:0]  dec_mode;
  logic [15:0] hex_acc;
  logic [1:0]  hex_digits;
  logic        hex_bad;
  logic        surr_wait;

  utf8_byte_t utf8_expected[$];
  utf8_byte_t run_q[$];

  int unsigned items_sent = 0;
  int unsigned bytes_seen = 0;
  int unsigned strings_closed = 0;
  int unsigned fail_count = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  json_string_unescape_utf8 uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_decoder();
    dec_mode   = MODE_TEXT;
    hex_acc    = '0;
    hex_digits = '0;
    hex_bad    = 1'b0;
    surr_wait  = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic e);
    utf8_byte_t r;
    r.data    = b;
    r.last    = 1'b0;
    r.str_end = e;
    run_q.push_back(r);
  endfunction

  function automatic void push_code(input logic [15:0] cp);
    if (cp < 16'h0080) begin
      push_byte(cp[7:0], 1'b0);
    end else if (cp < 16'h0800) begin
      push_byte({3'b110, cp[10:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b0);
    end else begin
      push_byte({4'b1110, cp[15:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b0);
    end
  endfunction

  function automatic void flush_surrogate();
    if (surr_wait) begin
      push_code(CP_REPL);
      surr_wait = 1'b0;
    end
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      ESC_N:   return CH_LF;
      ESC_T:   return CH_TAB;
      ESC_R:   return CH_CR;
      ESC_B:   return CH_BS;
      ESC_F:   return CH_FF;
      default: return c;
    endcase
  endfunction

  function automatic bit is_low_surr(input logic [15:0] cp);
    return cp >= CP_LOW_LO && cp <= CP_LOW_HI;
  endfunction

  function automatic void decode_step(input logic [7:0] c);
    logic [3:0]  nib;
    logic [15:0] cp;
    bit          bad;
    bit          paired;
    run_q.delete();
    case (dec_mode)
      MODE_HEX: begin
        nib = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) nib = 4'(c - CH_LOWER_A + 8'd10);
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) nib = 4'(c - CH_UPPER_A + 8'd10);
        else hex_bad = 1'b1;
        hex_acc = {hex_acc[11:0], nib};
        if (hex_digits != 2'd3) begin
          hex_digits++;
        end else begin
          cp         = hex_acc;
          bad        = hex_bad;
          paired     = 1'b0;
          dec_mode   = MODE_TEXT;
          hex_digits = '0;
          hex_bad    = 1'b0;
          hex_acc    = '0;
          if (surr_wait) begin
            surr_wait = 1'b0;
            push_code(CP_REPL);
            paired = !bad && is_low_surr(cp);
          end
          if (!paired) begin
            if (bad) push_code(CP_REPL);
            else if (cp >= CP_HIGH_LO && cp <= CP_HIGH_HI) surr_wait = 1'b1;
            else if (is_low_surr(cp)) push_code(CP_REPL);
            else push_code(cp);
          end
        end
      end
      MODE_ESC: begin
        if (c == CH_U) begin
          dec_mode   = MODE_HEX;
          hex_acc    = '0;
          hex_digits = '0;
          hex_bad    = 1'b0;
        end else begin
          flush_surrogate();
          push_byte(unescape(c), 1'b0);
          dec_mode = MODE_TEXT;
        end
      end
      default: begin
        if (c == CH_BACKSLASH) begin
          dec_mode = MODE_ESC;
        end else if (c == CH_QUOTE) begin
          flush_surrogate();
          push_byte(8'h00, 1'b1);
          clear_decoder();
          strings_closed++;
        end else begin
          flush_surrogate();
          push_byte(c, 1'b0);
        end
      end
    endcase
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) utf8_expected.push_back(run_q[i]);
  endfunction

  task automatic send_item(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_step(b);
    items_sent++;
    if (items_sent % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (utf8_expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return CH_ZERO + n;
    base = $urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A;
    return base + n - 8'd10;
  endfunction

  task automatic send_unicode(input logic [15:0] cp);
    send_item(CH_BACKSLASH);
    send_item(CH_U);
    for (int i = 3; i >= 0; i--) send_item(hex_char(cp[i*4 +: 4]));
  endtask

  task automatic send_escape(input logic [7:0] c);
    send_item(CH_BACKSLASH);
    send_item(c);
  endtask

  task automatic test_raw_bytes();
    send_item(8'h00);
    send_item(8'hFF);
    send_item(8'h55);
    send_item(8'hAA);
    send_item(CH_LF);
    send_item(CH_QUOTE);
    wait_drained();
  endtask

  task automatic test_escape_letters();
    send_escape(ESC_N);
    send_escape(ESC_T);
    send_escape(ESC_R);
    send_escape(ESC_B);
    send_escape(ESC_F);
    send_escape(CH_SLASH);
    send_escape(CH_QUOTE);
    send_escape(CH_BACKSLASH);
    send_escape("q");
    wait_drained();
  endtask

  task automatic test_unicode_escapes();
    send_unicode(16'h0000);
    send_unicode(16'hFFFF);
    send_unicode(16'h07FF);
    // bad hex, with the closing quote inside the digits
    send_item(CH_BACKSLASH);
    send_item(CH_U);
    send_item(CH_QUOTE);
    send_item("g");
    send_item("A");
    send_item("9");
    wait_drained();
  endtask

  task automatic test_surrogates();
    send_unicode(16'hD83D);
    send_unicode(16'hDE00);
    send_unicode(16'hDC00);
    send_unicode(16'hDBFF);
    send_item(CH_QUOTE);
    wait_drained();
  endtask

  function automatic logic [15:0] random_code();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(0, 1) ? $urandom_range(16'h0800, 16'hD7FF)
                                                : $urandom_range(16'hE000, 16'hFFFF));
      3:       return 16'($urandom_range(CP_HIGH_LO, CP_HIGH_HI));
      4:       return 16'($urandom_range(CP_LOW_LO, CP_LOW_HI));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic test_random_strings();
    int unsigned stop_at;
    int unsigned pause_at;
    int          pick;
    logic [7:0]  b;
    bit          paused;
    stop_at  = items_sent + RANDOM_ITEMS;
    pause_at = items_sent + RANDOM_ITEMS / 2;
    paused   = 1'b0;
    while (items_sent < stop_at) begin
      if (!paused && items_sent >= pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        b = 8'($urandom_range(0, 255));
        while (b == CH_BACKSLASH || b == CH_QUOTE) b = 8'($urandom_range(0, 255));
        send_item(b);
      end else if (pick < 35) begin
        send_item(8'($urandom_range(0, 255)));
      end else if (pick < 50) begin
        case ($urandom_range(0, 8))
          0: b = ESC_N;
          1: b = ESC_T;
          2: b = ESC_R;
          3: b = ESC_B;
          4: b = ESC_F;
          5: b = CH_SLASH;
          6: b = CH_QUOTE;
          7: b = CH_BACKSLASH;
          default: begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_U) b = 8'($urandom_range(0, 255));
          end
        endcase
        send_escape(b);
      end else if (pick < 72) begin
        send_unicode(random_code());
      end else if (pick < 82) begin
        send_unicode(16'($urandom_range(CP_HIGH_LO, CP_HIGH_HI)));
        send_unicode(16'($urandom_range(CP_LOW_LO, CP_LOW_HI)));
      end else if (pick < 88) begin
        // broken hex: some positions carry arbitrary bytes
        send_item(CH_BACKSLASH);
        send_item(CH_U);
        for (int i = 0; i < 4; i++) begin
          if ($urandom_range(0, 1)) send_item(8'($urandom_range(0, 255)));
          else send_item(hex_char(4'($urandom_range(0, 15))));
        end
      end else begin
        send_item(CH_QUOTE);
      end
    end
    send_item(CH_QUOTE);
    wait_drained();
  endtask

  initial begin : result_check
    int         gap;
    utf8_byte_t want;
    while (rst) @(posedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      bytes_seen++;
      if (utf8_expected.size() == 0) begin
        $error("unexpected result: out_byte %h run_last %b string_end %b",
               m_tdata, m_tlast, m_tuser);
        fail_count++;
      end else begin
        want = utf8_expected.pop_front();
        if (m_tdata !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want.str_end) begin
          $error("string_end: expected %b, got %b", want.str_end, m_tuser);
          fail_count++;
        end
      end
      if (bytes_seen % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned waited;
    clear_decoder();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_raw_bytes();
    test_escape_letters();
    test_unicode_escapes();
    test_surrogates();
    test_random_strings();
    waited = 0;
    while (utf8_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (utf8_expected.size() != 0) begin
      $error("%0d expected output bytes never arrived", utf8_expected.size());
      fail_count++;
    end
    $display("decoded %0d input items into %0d output bytes over %0d closed strings",
             items_sent, bytes_seen, strings_closed);
    $display("covered raw bytes, all escape letters, \\u forms, bad hex and surrogates");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: json_string_unescape_utf8.f
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8.sv
rtl/jsu_checker.sv
tb/sv/json_string_unescape_utf8_tb.sv
